// ===== sv/iac_pkg.sv =====
// Package for the impedance auto-range calibration core: payload types,
// register indexes, reset values and controller commands. No dependencies.
package iac_pkg;

    localparam int NUM_RANGES_DEF = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int MAG_W          = 24;
    localparam int NUM_W          = 48;

    localparam logic [CFG_IDX_W-1:0] REG_REF0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR0 = 3'd4;

    localparam logic [23:0] REF_RST0 = 24'd3650;
    localparam logic [23:0] REF_RST1 = 24'd36500;
    localparam logic [23:0] REF_RST2 = 24'd365000;
    localparam logic [23:0] REF_RST3 = 24'd1500000;
    localparam logic [23:0] FLR_RST0 = 24'd1000;
    localparam logic [23:0] FLR_RST1 = 24'd10000;
    localparam logic [23:0] FLR_RST2 = 24'd100000;
    localparam logic [23:0] FLR_RST3 = 24'd1000000;

    typedef struct packed {
        logic        func;
        logic [15:0] real_part;
        logic [15:0] imag_part;
    } iac_in_t;

    typedef struct packed {
        logic [31:0] impedance_ohms;
        logic [1:0]  range_used;
        logic        done_res;
        logic [1:0]  next_range;
        logic        zero_magnitude;
    } iac_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch input, start magnitude
        logic sqrt_step; // one root iteration
        logic mul_step;  // form numerator and compare products
        logic div_step;  // one quotient bit
        logic finish;    // form result, update range state
    } iac_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sqrt_last;
        logic div_last;
    } iac_stat_t;

endpackage

// ===== sv/impedance_autorange_calibrate_core.sv =====
// Top level of the impedance auto-range calibration core.
// Depends on iac_pkg, iac_ctrl and iac_datapath.
//
//  channel   signals                          request carries
//  s_        s_valid s_ready s_data           func, real_part, imag_part
//  m_        m_valid m_ready m_data           impedance, ranges, flags
//  cfg       cfg_we cfg_idx cfg_data          one 24-bit register write
//
// Each accepted request runs 24 root steps, one multiply/compare, 48
// restoring divide steps and a finish step. s_ready returns only after
// the finish step, so a new request is taken only once the last one is
// through. Reset is synchronous and restores register defaults and
// clears calibration. A result held by m_ready low stays in its register;
// the next request may run meanwhile and waits only at its finish step.
module impedance_autorange_calibrate_core
    import iac_pkg::*;
#(
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  iac_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output iac_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    iac_cmd_t  cmd;
    iac_stat_t stat;

    // sequence the shared root and divide loops
    iac_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .stat, .cmd
    );

    // hold range state, calibration and arithmetic
    iac_datapath #(.NUM_RANGES(NUM_RANGES)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_data(s_data),
        .cfg_we, .cfg_idx, .cfg_data, .out_data(m_data)
    );
endmodule

// ===== sv/iac_datapath.sv =====
// Datapath: magnitude root, numerator multiply, restoring divider, range state.
// Depends on iac_pkg.
module iac_datapath
    import iac_pkg::*;
#(
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  iac_cmd_t         cmd,
    output iac_stat_t        stat,
    input  iac_in_t          in_data,
    input  logic             cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output iac_out_t         out_data
);
    localparam int RW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int CMP_W = NUM_W + 5;

    logic [23:0] ref_reg   [4];
    logic [23:0] floor_reg [4];
    logic [MAG_W-1:0] cal_reg [NUM_RANGES];
    logic [RW-1:0] range_reg;

    // root: 48-bit radicand, 24-bit root, two radicand bits per step
    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        func_reg;

    logic [NUM_W-1:0] num_reg;
    logic        acc_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [MAG_W:0]   drem_reg;
    logic [5:0]  dcnt_reg;

    logic [15:0] abs_re, abs_im;
    logic [32:0] sumsq;
    logic [1:0]  reg_sel;
    logic [RW-1:0] range_last;
    logic [NUM_W-1:0] prod;
    logic [CMP_W-1:0] lhs_cmp, rhs_cmp;

    assign abs_re = in_data.real_part[15] ? 16'(-in_data.real_part) : in_data.real_part;
    assign abs_im = in_data.imag_part[15] ? 16'(-in_data.imag_part) : in_data.imag_part;
    assign sumsq  = 33'({16'd0, abs_re} * {16'd0, abs_re}) +
                    33'({16'd0, abs_im} * {16'd0, abs_im});
    assign reg_sel = 2'(range_reg);
    assign range_last = RW'(NUM_RANGES - 1);

    // 2*ref*cal against 21*floor*mag at full width
    assign prod    = {24'd0, ref_reg[reg_sel]} * {24'd0, cal_reg[range_reg]};
    assign lhs_cmp = {4'd0, prod, 1'b0};
    assign rhs_cmp = CMP_W'({24'd0, floor_reg[reg_sel]} * {24'd0, root_reg}) * CMP_W'(21);

    logic [25:0] trial;
    assign trial = {rem_reg[23:0], rad_reg[47:46]} - {root_reg, 2'b01};

    logic [MAG_W+1:0] dtrial;
    assign dtrial = {drem_reg, num_reg[NUM_W-1]} - {2'b00, root_reg};

    assign stat.sqrt_last = (cnt_reg == 5'd23);
    assign stat.div_last  = (dcnt_reg == 6'(NUM_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg[0] <= REF_RST0; ref_reg[1] <= REF_RST1;
            ref_reg[2] <= REF_RST2; ref_reg[3] <= REF_RST3;
            floor_reg[0] <= FLR_RST0; floor_reg[1] <= FLR_RST1;
            floor_reg[2] <= FLR_RST2; floor_reg[3] <= FLR_RST3;
            for (int i = 0; i < NUM_RANGES; i++) cal_reg[i] <= '0;
            range_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx < REG_FLOOR0)
                    ref_reg[cfg_idx[1:0]] <= cfg_data;
                else
                    floor_reg[cfg_idx[1:0]] <= cfg_data;
            end
            if (cmd.finish) begin
                if (!func_reg) cal_reg[range_reg] <= root_reg;
                if ((range_reg == range_last) || (func_reg && acc_reg && root_reg != '0))
                    range_reg <= '0;
                else
                    range_reg <= range_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rad_reg  <= {sumsq[31:0], 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            func_reg <= in_data.func;
        end
        if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            cnt_reg <= cnt_reg + 1'b1;
            if (!trial[25]) begin
                rem_reg  <= trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                rem_reg  <= {rem_reg[23:0], rad_reg[47:46]};
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
        if (cmd.mul_step) begin
            num_reg  <= prod;
            acc_reg  <= (lhs_cmp < rhs_cmp);
            quo_reg  <= '0;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!dtrial[MAG_W+1]) begin
                drem_reg <= dtrial[MAG_W:0];
                quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[MAG_W-1:0], num_reg[NUM_W-1]};
                quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            out_data.range_used <= 2'(range_reg);
            if (!func_reg) begin
                out_data.impedance_ohms <= '0;
                out_data.zero_magnitude <= 1'b0;
                out_data.done_res       <= (range_reg == range_last);
                out_data.next_range     <= (range_reg == range_last) ? 2'd0 : 2'(range_reg + 1'b1);
            end else begin
                logic dn;
                dn = (range_reg == range_last) || (acc_reg && root_reg != '0);
                out_data.zero_magnitude <= (root_reg == '0);
                if (root_reg == '0 || quo_reg[NUM_W-1:32] != '0)
                    out_data.impedance_ohms <= '1;
                else
                    out_data.impedance_ohms <= quo_reg[31:0];
                out_data.done_res   <= dn;
                out_data.next_range <= dn ? 2'd0 : 2'(range_reg + 1'b1);
            end
        end
    end
endmodule

// ===== sv/iac_ctrl.sv =====
// Controller: sequences root, multiply, divide and result hand-off.
// Depends on iac_pkg.
module iac_ctrl
    import iac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  iac_stat_t stat,
    output iac_cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_SQRT = 3'd1, ST_MUL = 3'd2,
                           ST_DIV = 3'd3, ST_FIN = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load = 1'b1; state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last) state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1; state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = ST_FIN;
            end
            ST_FIN: if (!mvalid_reg || m_ready) begin
                cmd.finish = 1'b1; mvalid_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// ===== sv/iac_checker.sv =====
// Port-level checker for the calibration core, bound to the top level.
// Depends on iac_pkg.
module iac_checker
    import iac_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input iac_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("request taken while busy");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_magnitude |-> m_data.impedance_ohms == 32'hFFFFFFFF)
        else $error("zero magnitude not saturated");
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.next_range == 2'd0)
        else $error("done without range reset");
endmodule

bind impedance_autorange_calibrate_core iac_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);

// ===== tb/impedance_autorange_calibrate_checker.sv =====
`timescale 1ns / 1ps
// Checker for the impedance auto-range calibration core: watches the request,
// result and register ports, predicts each result and compares. Uses iac_pkg.
module impedance_autorange_calibrate_checker
    import iac_pkg::*;
#(
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  iac_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  iac_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam logic FUNC_CAL = 1'b0;

    logic [23:0] ref_ohms   [4];
    logic [23:0] floor_ohms [4];
    logic [MAG_W-1:0] cal_mag [NUM_RANGES];
    int unsigned range_now;
    iac_out_t expected_results [$];

    function automatic logic [16:0] abs_part(logic [15:0] v);
        return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // integer root of (re^2 + im^2) << 16, giving a 16.8 magnitude
    function automatic logic [MAG_W-1:0] magnitude(logic [15:0] re, logic [15:0] im);
        logic [63:0] x, res, probe, a, b;
        a = 64'(abs_part(re));
        b = 64'(abs_part(im));
        x = (a * a + b * b) << 16;
        res = 0;
        probe = 64'h1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= res + probe) begin
                x = x - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res[MAG_W-1:0];
    endfunction

    task automatic predict_result(iac_in_t req);
        iac_out_t exp_r;
        int unsigned r, rg, nxt;
        logic [MAG_W-1:0] mag;
        logic [63:0] num, quo;
        logic done, accept;
        r = range_now % NUM_RANGES;
        rg = r & 3;
        mag = magnitude(req.real_part, req.imag_part);
        exp_r = '0;
        if (req.func == FUNC_CAL) begin
            cal_mag[r] = mag;
            done = (r == NUM_RANGES - 1);
        end else begin
            num = 64'(ref_ohms[rg]) * 64'(cal_mag[r]);
            if (mag == 0) begin
                exp_r.impedance_ohms = 32'hFFFF_FFFF;
                exp_r.zero_magnitude = 1'b1;
                accept = 1'b0;
            end else begin
                quo = num / 64'(mag);
                exp_r.impedance_ohms = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                accept = (2 * num) < (64'd21 * 64'(floor_ohms[rg]) * 64'(mag));
            end
            done = accept || (r == NUM_RANGES - 1);
        end
        nxt = done ? 0 : r + 1;
        range_now = nxt;
        exp_r.range_used = r[1:0];
        exp_r.done_res   = done;
        exp_r.next_range = nxt[1:0];
        expected_results.push_back(exp_r);
    endtask

    task automatic compare_result(iac_out_t got);
        iac_out_t want;
        if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.impedance_ohms !== want.impedance_ohms) begin
            $error("impedance_ohms expected %0d actual %0d", want.impedance_ohms,
                   got.impedance_ohms);
            fail_count++;
        end
        if (got.range_used !== want.range_used) begin
            $error("range_used expected %0d actual %0d", want.range_used, got.range_used);
            fail_count++;
        end
        if (got.done_res !== want.done_res) begin
            $error("done_res expected %0d actual %0d", want.done_res, got.done_res);
            fail_count++;
        end
        if (got.next_range !== want.next_range) begin
            $error("next_range expected %0d actual %0d", want.next_range, got.next_range);
            fail_count++;
        end
        if (got.zero_magnitude !== want.zero_magnitude) begin
            $error("zero_magnitude expected %0d actual %0d", want.zero_magnitude,
                   got.zero_magnitude);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    assign pending = expected_results.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            ref_ohms[0] = REF_RST0; ref_ohms[1] = REF_RST1;
            ref_ohms[2] = REF_RST2; ref_ohms[3] = REF_RST3;
            floor_ohms[0] = FLR_RST0; floor_ohms[1] = FLR_RST1;
            floor_ohms[2] = FLR_RST2; floor_ohms[3] = FLR_RST3;
            for (int i = 0; i < NUM_RANGES; i++) cal_mag[i] = '0;
            range_now = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx < REG_FLOOR0) ref_ohms[cfg_idx[1:0]] = cfg_data;
                else floor_ohms[cfg_idx[1:0]] = cfg_data;
            end
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) predict_result(s_data);
        end
    end

endmodule

// ===== tb/tb_impedance_autorange_calibrate_core.sv =====
`timescale 1ns / 1ps
// Top of the testbench for impedance_autorange_calibrate_core: clock, reset,
// stimulus and verdict. Uses iac_pkg and impedance_autorange_calibrate_checker.
module tb_impedance_autorange_calibrate_core;
    import iac_pkg::*;

    localparam logic FUNC_CAL   = 1'b0;
    localparam logic FUNC_MEAS  = 1'b1;
    localparam int   IDLE_LIMIT = 3000;   // quiet cycles before giving up
    localparam int   HOLD_LEN   = 400;    // long receiver hold-off
    localparam int   PHASE_LEN  = 125;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    iac_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    iac_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count, pending;
    int sent_count = 0;
    int result_count = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;       // no idling on either side
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #5 aclk = ~aclk;

    impedance_autorange_calibrate_core dut (.*);

    impedance_autorange_calibrate_checker checker_i (.*);

    // Give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (m_valid && m_ready) result_count <= result_count + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random back-pressure bursts, plus one long hold-off on request
    // so the core fills up and stalls its input.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request, hold it until taken, then maybe drop valid for a burst.
    task automatic send_request(logic func, logic [15:0] re, logic [15:0] im);
        s_valid <= 1'b1;
        s_data  <= '{func: func, real_part: re, imag_part: im};
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(int idx, logic [23:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'(idx);
        cfg_data <= val;
        @(posedge aclk);
        cfg_we   <= 1'b0;
    endtask

    // Drop valid and wait until every outstanding result is back.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Mostly full-range random parts, now and then an extreme or a tiny value.
    function automatic logic [15:0] pick_part;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        k = 0;
        while (k < count) begin
            if (sent_count >= 260) hold_req = 1'b1;
            if (k >= count - 40 && sent_count > 400) calm = 1'b1;
            if ($urandom_range(0, 9) < 7) begin
                // calibration sweep over all ranges, then a measurement run
                for (int i = 0; i < 4; i++) send_request(FUNC_CAL, pick_part(), pick_part());
                for (int i = 0; i < 4; i++) send_request(FUNC_MEAS, pick_part(), pick_part());
                k += 8;
            end else begin
                send_request(1'($urandom), pick_part(), pick_part());
                k++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: measure before any calibration, then extremes, zero magnitude.
        send_request(FUNC_MEAS, 16'h0100, 16'h0000);
        send_request(FUNC_MEAS, 16'h0000, 16'h0000);
        send_request(FUNC_CAL,  16'h8000, 16'h8000);
        send_request(FUNC_CAL,  16'h7FFF, 16'h7FFF);
        send_request(FUNC_CAL,  16'h8000, 16'h0000);
        send_request(FUNC_CAL,  16'h0000, 16'hFFFF);
        send_request(FUNC_MEAS, 16'h0000, 16'h0000);
        send_request(FUNC_MEAS, 16'h0001, 16'h0000);
        send_request(FUNC_MEAS, 16'h7FFF, 16'h8000);
        send_request(FUNC_MEAS, 16'h8000, 16'h7FFF);
        send_request(FUNC_MEAS, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_CAL,  16'h1234, 16'hEDCB);
        send_request(FUNC_MEAS, 16'h1234, 16'hEDCB);
        drain();

        // Extreme settings: huge references with zero floors never accept.
        for (int i = 0; i < 4; i++) write_reg(REG_REF0 + i, 24'hFFFFFF);
        for (int i = 0; i < 4; i++) write_reg(REG_FLOOR0 + i, 24'h000000);
        for (int i = 0; i < 4; i++) send_request(FUNC_CAL, 16'h7FFF, 16'h8000);
        for (int i = 0; i < 4; i++) send_request(FUNC_MEAS, 16'h0001, 16'h0000);
        random_phase(PHASE_LEN);
        drain();

        // Smallest references with the largest floors accept at once unless the magnitude is zero.
        for (int i = 0; i < 4; i++) write_reg(REG_REF0 + i, 24'h000001);
        for (int i = 0; i < 4; i++) write_reg(REG_FLOOR0 + i, 24'hFFFFFF);
        random_phase(PHASE_LEN);
        drain();

        // Random settings.
        for (int i = 0; i < 4; i++) write_reg(REG_REF0 + i, 24'($urandom_range(1, 24'hFFFFFF)));
        for (int i = 0; i < 4; i++) write_reg(REG_FLOOR0 + i, 24'($urandom));
        random_phase(PHASE_LEN);
        drain();

        // Back to the power-on values for the last stretch.
        write_reg(REG_REF0 + 0, REF_RST0);   write_reg(REG_REF0 + 1, REF_RST1);
        write_reg(REG_REF0 + 2, REF_RST2);   write_reg(REG_REF0 + 3, REF_RST3);
        write_reg(REG_FLOOR0 + 0, FLR_RST0); write_reg(REG_FLOOR0 + 1, FLR_RST1);
        write_reg(REG_FLOOR0 + 2, FLR_RST2); write_reg(REG_FLOOR0 + 3, FLR_RST3);
        random_phase(PHASE_LEN);
        drain();

        $display("covered %0d requests and %0d results over four register settings,",
                 sent_count, result_count);
        $display("with random idling, one long output hold-off and a calm final stretch");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
